>>> sv/decimal_text_to_fixed_point_core_macros.svh
// Assertion macros for the decimal text to fixed point core.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_CORE_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_CORE_MACROS_SVH

// condition holds on every clock edge out of reset
`define DTTFP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define DTTFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dttfp_pkg.sv
// Shared types and constants for the decimal text to fixed point core.
// No dependencies.
package dttfp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RADIX   = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_E     = 8'h65;

  // saturation magnitudes; MAG_NEG is also the bit pattern of the most negative value
  localparam logic [VALUE_W-1:0] MAG_POS   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VALUE_W-1:0] MAG_NEG   = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] LIM_DIV10 = 64'd922337203685477580;

  // divide-by-ten unit: bits retired per cycle
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam int unsigned DIV_STEPS     = VALUE_W / DIV_STEP_BITS;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [3:0] k);
    logic [VALUE_W-1:0] p;
    case (k)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      4'd10:   p = 64'd10000000000;
      4'd11:   p = 64'd100000000000;
      4'd12:   p = 64'd1000000000000;
      4'd13:   p = 64'd10000000000000;
      4'd14:   p = 64'd100000000000000;
      default: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

endpackage

>>> sv/dttfp_in_if.sv
// Input channel: one text character word per handshake.
// Depends on dttfp_pkg.
interface dttfp_in_if import dttfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

>>> sv/dttfp_out_if.sv
// Output channel: one fixed point result word per handshake.
// Depends on dttfp_pkg.
interface dttfp_out_if import dttfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      terminator_consumed;
  logic                      overflow;

  modport source (output valid, output value, output terminator_consumed, output overflow,
                  input ready);
  modport sink   (input valid, input value, input terminator_consumed, input overflow,
                  output ready);
endinterface

>>> sv/dttfp_div10.sv
// Iterative unsigned divide by ten, DIV_STEP_BITS quotient bits per cycle.
// Depends on dttfp_pkg.
module dttfp_div10 import dttfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] dividend_i,
  output logic [VALUE_W-1:0] quotient_o,
  output div_stat_t          stat_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic [VALUE_W-1:0]       num_q, num_d;
  logic [3:0]               rem_q, rem_v;
  logic [4:0]               r5;
  logic [DIV_STEP_BITS-1:0] qbyte;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q, done_q;

  // long division, MSB first; dividend bits shift out, quotient bits shift in
  always_comb begin
    rem_v = rem_q;
    qbyte = '0;
    r5    = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      r5 = {rem_v, num_q[VALUE_W-1-i]};
      if (r5 >= 5'(RADIX)) begin
        rem_v = 4'(r5 - 5'(RADIX));
        qbyte[DIV_STEP_BITS-1-i] = 1'b1;
      end else begin
        rem_v = r5[3:0];
      end
    end
    num_d = {num_q[VALUE_W-DIV_STEP_BITS-1:0], qbyte};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      num_q  <= dividend_i;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_v;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o  = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> sv/decimal_text_to_fixed_point_core.sv
// Decimal text to signed fixed point converter, one character word per handshake.
// A non-ending character is absorbed while idle; an ending word runs the fraction restoring divider,
// sum and range check, then the exponent loop (divide-by-ten unit for each negative exponent step).
// Input stalls until the result loads into the output register; throughput is bounded by both loops.
// Reset: rst_ni asynchronous active low, clears parse state and output valid; no clearing pass.
// Depends on dttfp_pkg, dttfp_in_if, dttfp_out_if, dttfp_div10 and the macros header.
`include "decimal_text_to_fixed_point_core_macros.svh"

module decimal_text_to_fixed_point_core import dttfp_pkg::*; #(
  parameter int unsigned FRACTION_BITS       = 32,
  parameter int unsigned MAX_FRACTION_DIGITS = 9,
  parameter int unsigned MAX_EXPONENT        = 99
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dttfp_in_if.sink    in_i,
  dttfp_out_if.source out_o
);

  localparam logic [VALUE_W-1:0] POW_MAX = pow10(4'(MAX_FRACTION_DIGITS));
  localparam int unsigned FAW = $clog2(POW_MAX);
  localparam int unsigned PW  = $clog2(POW_MAX + 64'd1);
  localparam int unsigned CW  = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int unsigned EW  = $clog2(MAX_EXPONENT + 1);
  localparam int unsigned IW  = $clog2(FRACTION_BITS);
  localparam logic [VALUE_W-1:0] INT_LIM_POS = MAG_POS >> FRACTION_BITS;
  localparam logic [VALUE_W-1:0] INT_LIM_NEG = MAG_NEG >> FRACTION_BITS;

  typedef enum logic [2:0] {PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG} phase_e;
  typedef enum logic [2:0] {S_IDLE, S_FRAC, S_SUM, S_CHK, S_EXP, S_DIV, S_DONE} state_e;

  state_e                   state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic [31:0]              int_acc_q, int_acc_d;
  logic [FAW-1:0]           frac_acc_q, frac_acc_d;
  logic [CW-1:0]            frac_cnt_q, frac_cnt_d;
  logic [EW-1:0]            exp_acc_q, exp_acc_d;
  logic                     exp_neg_q, exp_neg_d;
  logic                     ovf_seen_q, ovf_seen_d;
  logic [PW-1:0]            rem_q, rem_d;
  logic [PW-1:0]            pow_q, pow_d;
  logic [FRACTION_BITS-1:0] bits_q, bits_d;
  logic [IW-1:0]            iter_q, iter_d;
  logic [VALUE_W-1:0]       q_q, q_d;
  logic                     ovf_q, ovf_d;
  logic                     con_q, con_d;
  logic                     out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]       out_value_q, out_value_d;
  logic                     out_con_q, out_con_d;
  logic                     out_ovf_q, out_ovf_d;

  logic                     in_acc, is_digit, term, term_con, out_load;
  logic [CHAR_W-1:0]        char_off;
  logic [3:0]               dig_val;
  logic [35:0]              int_next;
  logic [FAW+3:0]           frac_next;
  logic [EW+3:0]            exp_next;
  logic [EW-1:0]            exp_sat;
  logic [PW:0]              rem_shift;
  logic                     rem_ge;
  logic [VALUE_W-1:0]       mag_lim, int_lim, q_times10;
  logic                     div_start;
  logic [VALUE_W-1:0]       div_quo;
  div_stat_t                div_stat;

  dttfp_div10 u_div10 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (q_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign is_digit  = in_i.character inside {[CHAR_ZERO:CHAR_NINE]};
  assign char_off  = in_i.character - CHAR_ZERO;
  assign dig_val   = char_off[3:0];
  assign int_next  = ({4'b0, int_acc_q} << 3) + ({4'b0, int_acc_q} << 1) + 36'(dig_val);
  assign frac_next = ({4'b0, frac_acc_q} << 3) + ({4'b0, frac_acc_q} << 1)
                   + (FAW+4)'(dig_val);
  assign exp_next  = ({4'b0, exp_acc_q} << 3) + ({4'b0, exp_acc_q} << 1) + (EW+4)'(dig_val);
  assign exp_sat   = (exp_next > (EW+4)'(MAX_EXPONENT)) ? EW'(MAX_EXPONENT)
                                                        : exp_next[EW-1:0];

  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, pow_q};
  assign mag_lim   = neg_q ? MAG_NEG : MAG_POS;
  assign int_lim   = neg_q ? INT_LIM_NEG : INT_LIM_POS;
  assign q_times10 = (q_q << 3) + (q_q << 1);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    int_acc_d   = int_acc_q;
    frac_acc_d  = frac_acc_q;
    frac_cnt_d  = frac_cnt_q;
    exp_acc_d   = exp_acc_q;
    exp_neg_d   = exp_neg_q;
    ovf_seen_d  = ovf_seen_q;
    rem_d       = rem_q;
    pow_d       = pow_q;
    bits_d      = bits_q;
    iter_d      = iter_q;
    q_d         = q_q;
    ovf_d       = ovf_q;
    con_d       = con_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    out_con_d   = out_con_q;
    out_ovf_d   = out_ovf_q;
    div_start   = 1'b0;
    term        = 1'b0;
    term_con    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.end_of_text) begin
            term = 1'b1;
          end else begin
            case (phase_q)
              PH_FRAC: begin
                if (is_digit) begin
                  if (frac_cnt_q < CW'(MAX_FRACTION_DIGITS)) begin
                    frac_acc_d = frac_next[FAW-1:0];
                    frac_cnt_d = frac_cnt_q + 1'b1;
                  end
                end else if (in_i.character == CHAR_E) begin
                  phase_d = PH_ESIGN;
                end else begin
                  term     = 1'b1;
                  term_con = (in_i.character == CHAR_F);
                end
              end
              PH_ESIGN: begin
                if (in_i.character == CHAR_MINUS) begin
                  exp_neg_d = 1'b1;
                  phase_d   = PH_EDIG;
                end else if (in_i.character == CHAR_PLUS) begin
                  phase_d = PH_EDIG;
                end else if (is_digit) begin
                  exp_acc_d = exp_sat;
                  phase_d   = PH_EDIG;
                end else begin
                  term     = 1'b1;
                  term_con = 1'b1;
                end
              end
              PH_EDIG: begin
                if (is_digit) begin
                  exp_acc_d = exp_sat;
                end else begin
                  term     = 1'b1;
                  term_con = 1'b1;
                end
              end
              default: begin
                if (is_digit) begin
                  if (int_next[35:32] != 4'd0) begin
                    int_acc_d  = 32'hffff_ffff;
                    ovf_seen_d = 1'b1;
                  end else begin
                    int_acc_d = int_next[31:0];
                  end
                end else if (in_i.character == CHAR_MINUS) begin
                  neg_d = 1'b1;
                end else if (in_i.character == CHAR_DOT) begin
                  phase_d = PH_FRAC;
                end else if (in_i.character == CHAR_E) begin
                  phase_d = PH_ESIGN;
                end else begin
                  term     = 1'b1;
                  term_con = (in_i.character == CHAR_F);
                end
              end
            endcase
          end
          if (term) begin
            con_d   = term_con;
            rem_d   = PW'(frac_acc_q);
            pow_d   = PW'(pow10(4'(frac_cnt_q)));
            bits_d  = '0;
            iter_d  = '0;
            state_d = S_FRAC;
          end
        end
      end
      S_FRAC: begin
        bits_d = {bits_q[FRACTION_BITS-2:0], rem_ge};
        rem_d  = rem_ge ? PW'(rem_shift - {1'b0, pow_q}) : rem_shift[PW-1:0];
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(FRACTION_BITS - 1)) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        ovf_d   = ovf_seen_q || (VALUE_W'(int_acc_q) > int_lim);
        q_d     = (VALUE_W'(int_acc_q) << FRACTION_BITS) + VALUE_W'(bits_q);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (q_q > mag_lim) begin
          ovf_d = 1'b1;
        end
        state_d = S_EXP;
      end
      S_EXP: begin
        if (ovf_q || exp_acc_q == '0) begin
          state_d = S_DONE;
        end else if (exp_neg_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (q_q > LIM_DIV10) begin
          ovf_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          q_d       = q_times10;
          exp_acc_d = exp_acc_q - 1'b1;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          q_d       = div_quo;
          exp_acc_d = exp_acc_q - 1'b1;
          state_d   = S_EXP;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_con_d   = con_q;
          out_ovf_d   = ovf_q;
          if (ovf_q) begin
            out_value_d = mag_lim;
          end else begin
            out_value_d = neg_q ? (VALUE_W'(0) - q_q) : q_q;
          end
          phase_d    = PH_INT;
          neg_d      = 1'b0;
          int_acc_d  = '0;
          frac_acc_d = '0;
          frac_cnt_d = '0;
          exp_acc_d  = '0;
          exp_neg_d  = 1'b0;
          ovf_seen_d = 1'b0;
          ovf_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_INT;
      neg_q       <= 1'b0;
      int_acc_q   <= '0;
      frac_acc_q  <= '0;
      frac_cnt_q  <= '0;
      exp_acc_q   <= '0;
      exp_neg_q   <= 1'b0;
      ovf_seen_q  <= 1'b0;
      rem_q       <= '0;
      pow_q       <= '0;
      bits_q      <= '0;
      iter_q      <= '0;
      q_q         <= '0;
      ovf_q       <= 1'b0;
      con_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_con_q   <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      int_acc_q   <= int_acc_d;
      frac_acc_q  <= frac_acc_d;
      frac_cnt_q  <= frac_cnt_d;
      exp_acc_q   <= exp_acc_d;
      exp_neg_q   <= exp_neg_d;
      ovf_seen_q  <= ovf_seen_d;
      rem_q       <= rem_d;
      pow_q       <= pow_d;
      bits_q      <= bits_d;
      iter_q      <= iter_d;
      q_q         <= q_d;
      ovf_q       <= ovf_d;
      con_q       <= con_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_con_q   <= out_con_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.value               = out_value_q;
  assign out_o.terminator_consumed = out_con_q;
  assign out_o.overflow            = out_ovf_q;

  `DTTFP_ASSERT_IMP(a_ovf_saturates, out_o.valid && out_o.overflow, (out_o.value == MAG_POS || out_o.value == MAG_NEG), "overflow word without saturated value")
  `DTTFP_ASSERT(a_frac_cnt_max, frac_cnt_q <= CW'(MAX_FRACTION_DIGITS), "fraction digit count past limit")
  `DTTFP_ASSERT(a_exp_max, exp_acc_q <= EW'(MAX_EXPONENT), "exponent past limit")
  `DTTFP_ASSERT_NEXT(a_clear_after_load, out_load, (phase_q == PH_INT && int_acc_q == '0 && frac_cnt_q == '0 && !ovf_seen_q && !neg_q), "parse state not cleared after result")
  `DTTFP_ASSERT_IMP(a_div_in_state, div_stat.busy || div_stat.done, state_q == S_DIV, "divider active outside divide state")

endmodule

>>> bench/decimal_text_to_fixed_point_core_tb.sv
// Self-checking bench for decimal_text_to_fixed_point_core: drives number text words and checks
// each fixed point result word against a parser model or typed row, under varying backpressure.
// Depends on dttfp_pkg, dttfp_in_if, dttfp_out_if and the core.
`timescale 1ns / 100ps

module decimal_text_to_fixed_point_core_tb;
  import dttfp_pkg::*;

  localparam int unsigned FRACTION_BITS       = 32;
  localparam int unsigned MAX_FRACTION_DIGITS = 9;
  localparam int unsigned MAX_EXPONENT        = 99;
  localparam int unsigned RANDOM_WORDS        = 1300;
  localparam int unsigned STALL_LIMIT         = 20000;
  localparam int unsigned DRAIN_CYCLES        = 1100;
  localparam int unsigned DIRECTED_ROWS       = 26;

  localparam logic [CHAR_W-1:0] CHAR_COMMA    = 8'h2c;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_RBRACKET = 8'h5d;
  localparam logic [CHAR_W-1:0] CHAR_RBRACE   = 8'h7d;
  localparam logic [CHAR_W-1:0] CHAR_X        = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_FIVE     = 8'h35;
  localparam logic [CHAR_W-1:0] CHAR_ONE      = 8'h31;

  typedef enum logic [2:0] {
    PH_INTEGER,
    PH_FRACTION,
    PH_EXP_SIGN,
    PH_EXP_DIGITS
  } parse_phase_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               consumed;
    logic               overflow;
  } fixed_result_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               eot;
    logic               typed;
    logic [VALUE_W-1:0] value;
    logic               consumed;
    logic               overflow;
  } text_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  dttfp_in_if  in_ch ();
  dttfp_out_if out_ch ();

  decimal_text_to_fixed_point_core #(
    .FRACTION_BITS      (FRACTION_BITS),
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
    .MAX_EXPONENT       (MAX_EXPONENT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // parser model state
  parse_phase_e parse_phase;
  logic         num_negative;
  logic [31:0]  int_acc;
  logic [29:0]  frac_acc;
  logic [3:0]   frac_digits;
  logic [6:0]   exp_acc;
  logic         exp_negative;
  logic         int_saturated;

  fixed_result_t pending_results[$];
  int unsigned   mismatches   = 0;
  int unsigned   words_sent   = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   tx_idle_pct  = 33;
  int unsigned   rx_idle_pct  = 85;

  // directed text: empty numbers, saturation on exponent and on integer part,
  // signed fraction with negative exponent
  text_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00,      1'b1, 1'b1, 64'd0,   1'b0, 1'b0},
    '{CHAR_F,     1'b0, 1'b1, 64'd0,   1'b1, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_E,     1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_X,     1'b0, 1'b1, MAG_POS, 1'b1, 1'b1},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{8'hff,      1'b1, 1'b1, MAG_POS, 1'b0, 1'b1},
    '{CHAR_MINUS, 1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_DOT,   1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_FIVE,  1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_E,     1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_MINUS, 1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_ONE,   1'b0, 1'b0, 64'd0,   1'b0, 1'b0},
    '{CHAR_COMMA, 1'b0, 1'b0, 64'd0,   1'b0, 1'b0}
  };

  function automatic void clear_parser();
    parse_phase   = PH_INTEGER;
    num_negative  = 1'b0;
    int_acc       = '0;
    frac_acc      = '0;
    frac_digits   = '0;
    exp_acc       = '0;
    exp_negative  = 1'b0;
    int_saturated = 1'b0;
  endfunction

  function automatic fixed_result_t finish_number(input logic consumed);
    fixed_result_t res;
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] p;
    logic               ovf;
    int                 i;
    lim = num_negative ? MAG_NEG : MAG_POS;
    ovf = int_saturated;
    q   = '0;
    if (!ovf) begin
      if (64'(int_acc) > (lim >> FRACTION_BITS)) begin
        ovf = 1'b1;
      end else begin
        p = 64'd1;
        for (i = 0; i < int'(frac_digits); i++) p = p * RADIX;
        q = (64'(int_acc) << FRACTION_BITS) + ((64'(frac_acc) << FRACTION_BITS) / p);
        if (q > lim) ovf = 1'b1;
      end
    end
    if (!ovf) begin
      for (i = 0; i < int'(exp_acc); i++) begin
        if (exp_negative) begin
          q = q / RADIX;
        end else if (q > lim / RADIX) begin
          ovf = 1'b1;
          break;
        end else begin
          q = q * RADIX;
        end
      end
    end
    if (ovf) q = lim;
    res.value    = num_negative ? -q : q;
    res.consumed = consumed;
    res.overflow = ovf;
    clear_parser();
    return res;
  endfunction

  function automatic void add_exp_digit(input logic [3:0] d);
    int unsigned t;
    t = int'(exp_acc) * RADIX + d;
    exp_acc = (t > MAX_EXPONENT) ? 7'(MAX_EXPONENT) : 7'(t);
  endfunction

  // returns 1 when the word ends a number, with the fixed point result in res
  function automatic bit parse_char(input logic [CHAR_W-1:0] ch, input logic eot,
                                    output fixed_result_t res);
    logic               is_dig;
    logic [3:0]         d;
    logic [VALUE_W-1:0] t;
    is_dig = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    d      = 4'(ch - CHAR_ZERO);
    res    = '0;
    if (eot) begin
      res = finish_number(1'b0);
      return 1'b1;
    end
    case (parse_phase)
      PH_FRACTION: begin
        if (is_dig) begin
          if (frac_digits < MAX_FRACTION_DIGITS) begin
            frac_acc    = 30'(64'(frac_acc) * RADIX + d);
            frac_digits = frac_digits + 4'd1;
          end
          return 1'b0;
        end
        if (ch == CHAR_E) begin
          parse_phase = PH_EXP_SIGN;
          return 1'b0;
        end
        res = finish_number(ch == CHAR_F);
        return 1'b1;
      end
      PH_EXP_SIGN: begin
        if (ch == CHAR_MINUS) begin
          exp_negative = 1'b1;
          parse_phase  = PH_EXP_DIGITS;
          return 1'b0;
        end
        if (ch == CHAR_PLUS) begin
          parse_phase = PH_EXP_DIGITS;
          return 1'b0;
        end
        if (is_dig) begin
          add_exp_digit(d);
          parse_phase = PH_EXP_DIGITS;
          return 1'b0;
        end
        res = finish_number(1'b1);
        return 1'b1;
      end
      PH_EXP_DIGITS: begin
        if (is_dig) begin
          add_exp_digit(d);
          return 1'b0;
        end
        res = finish_number(1'b1);
        return 1'b1;
      end
      default: begin
        if (is_dig) begin
          t = 64'(int_acc) * RADIX + d;
          if (t > 64'hffff_ffff) begin
            t             = 64'hffff_ffff;
            int_saturated = 1'b1;
          end
          int_acc = t[31:0];
          return 1'b0;
        end
        if (ch == CHAR_MINUS) begin
          num_negative = 1'b1;
          return 1'b0;
        end
        if (ch == CHAR_DOT) begin
          parse_phase = PH_FRACTION;
          return 1'b0;
        end
        if (ch == CHAR_E) begin
          parse_phase = PH_EXP_SIGN;
          return 1'b0;
        end
        res = finish_number(ch == CHAR_F);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic text_row_t plain_word(input logic [CHAR_W-1:0] ch, input logic eot);
    text_row_t row;
    row     = '0;
    row.ch  = ch;
    row.eot = eot;
    return row;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input text_row_t row);
    fixed_result_t predicted;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.character   <= row.ch;
    in_ch.end_of_text <= row.eot;
    do @(posedge clk_i); while (!in_ch.ready);
    if (parse_char(row.ch, row.eot, predicted))
      pending_results.push_back(row.typed ? fixed_result_t'{row.value, row.consumed, row.overflow}
                                          : predicted);
    words_sent++;
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    send_word(plain_word(ch, 1'b0));
  endtask

  // mostly well-formed numbers with random content, some raw noise
  task automatic send_random_number();
    logic [CHAR_W-1:0] enders [4];
    int                n;
    int                k;
    enders = '{CHAR_COMMA, CHAR_SPACE, CHAR_RBRACKET, CHAR_RBRACE};
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 4)) send_word(plain_word(8'($urandom), $urandom_range(7) == 0));
      return;
    end
    if ($urandom_range(3) == 0) send_char(CHAR_MINUS);
    n = ($urandom_range(19) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 6);
    for (k = 0; k < n; k++) begin
      send_char(rand_digit());
      if ($urandom_range(63) == 0) send_char(CHAR_MINUS);
    end
    if ($urandom_range(99) < 60) begin
      send_char(CHAR_DOT);
      n = $urandom_range(0, 12);
      for (k = 0; k < n; k++) send_char(rand_digit());
    end
    if ($urandom_range(99) < 35) begin
      send_char(CHAR_E);
      case ($urandom_range(2))
        1: send_char(CHAR_MINUS);
        2: send_char(CHAR_PLUS);
        default: ;
      endcase
      n = ($urandom_range(3) == 0) ? 2 : $urandom_range(0, 1);
      for (k = 0; k < n; k++) send_char(rand_digit());
    end
    k = $urandom_range(99);
    if (k < 30) send_char(CHAR_F);
    else if (k < 50) send_word(plain_word(8'($urandom), 1'b1));
    else if (k < 90) send_char(enders[$urandom_range(3)]);
    else send_char(8'($urandom));
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    fixed_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", out_ch.value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value !== want.value)
          report_mismatch("value", out_ch.value, want.value);
        if (out_ch.terminator_consumed !== want.consumed)
          report_mismatch("terminator_consumed", 64'(out_ch.terminator_consumed),
                          64'(want.consumed));
        if (out_ch.overflow !== want.overflow)
          report_mismatch("overflow", 64'(out_ch.overflow), 64'(want.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.character   <= '0;
    in_ch.end_of_text <= 1'b0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (words_sent < DIRECTED_ROWS + RANDOM_WORDS * (ph + 1) / 3) send_random_number();
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
